/* design/dmwbc_pkg.sv */
// Shared constants, types and helpers for the direct-mapped write-back cache core.
// Depends on nothing; every design file takes its names by scoped reference.
`default_nettype none

package dmwbc_pkg;

    // Sizing (all counts are powers of two)
    localparam int LINE_COUNT     = 4;
    localparam int WORDS_PER_LINE = 16;
    localparam int MEMORY_ROWS    = 16;
    localparam int DATA_WIDTH     = 32;

    // Fixed request/result field widths
    localparam int ADDR_W = 8;
    localparam int PORT_W = 32;

    // Derived widths
    localparam int OFF_W     = $clog2(WORDS_PER_LINE);
    localparam int IDX_W     = $clog2(LINE_COUNT);
    localparam int TAG_W     = ADDR_W - OFF_W - IDX_W;
    localparam int CACHE_AW  = IDX_W + OFF_W;
    localparam int CACHE_WORDS = LINE_COUNT * WORDS_PER_LINE;
    localparam int MEM_WORDS = MEMORY_ROWS * WORDS_PER_LINE;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int WORD_W    = (DATA_WIDTH < PORT_W) ? DATA_WIDTH : PORT_W;

    localparam logic [WORD_W-1:0] RESET_WORD = WORD_W'(5);

    typedef logic [WORD_W-1:0] t_word;

    // Wrap a word address onto the backing store.
    function automatic logic [MEM_AW-1:0] mem_addr(input logic [ADDR_W-1:0] a);
        return MEM_AW'(a);
    endfunction

endpackage

`default_nettype wire

/* design/direct_mapped_writeback_cache_core.sv */
// Direct-mapped write-back cache with its backing store, both held in on-chip memories.
// Depends on dmwbc_pkg for sizing, the word type and address wrapping.
//
//  Channel   Direction  Signals                                  Handshake
//  request   in         i_mode, i_address, i_write_data          start & !busy
//  result    out        o_read_data, o_hit                       o_valid, one cycle, no stall
//
// A write (hit or miss) and a read hit strobe the result in the cycle after the request
// while busy stays low. A read miss on a clean line runs a line fill through the backing
// store read port; on a dirty line a write-back through the cache read port comes
// first, then the fill.
// After reset busy stays high while the backing store, all MEM_WORDS words (256 by
// default), is swept to its reset word. The result side cannot stall.
`default_nettype none

module direct_mapped_writeback_cache_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_mode,
    input  wire logic [dmwbc_pkg::ADDR_W-1:0]       i_address,
    input  wire logic signed [dmwbc_pkg::PORT_W-1:0] i_write_data,
    output logic                                    o_valid,
    output logic signed [dmwbc_pkg::PORT_W-1:0]     o_read_data,
    output logic                                    o_hit
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WB,
        S_FILL
    } t_state;

    t_state r_state;

    // Line metadata lives in flops: it is tiny and read at the request index.
    logic [dmwbc_pkg::LINE_COUNT-1:0] r_valid;
    logic [dmwbc_pkg::LINE_COUNT-1:0] r_dirty;
    logic [dmwbc_pkg::TAG_W-1:0]      r_tag [dmwbc_pkg::LINE_COUNT];

    // Line data and backing store: one write and one registered read port each.
    dmwbc_pkg::t_word r_cache_mem [dmwbc_pkg::CACHE_WORDS];
    dmwbc_pkg::t_word r_back_mem  [dmwbc_pkg::MEM_WORDS];
    dmwbc_pkg::t_word r_cache_q;
    dmwbc_pkg::t_word r_back_q;

    logic                             cache_we;
    logic [dmwbc_pkg::CACHE_AW-1:0]   cache_waddr;
    dmwbc_pkg::t_word                 cache_wdata;
    logic                             cache_re;
    logic [dmwbc_pkg::CACHE_AW-1:0]   cache_raddr;
    logic                             back_we;
    logic [dmwbc_pkg::MEM_AW-1:0]     back_waddr;
    dmwbc_pkg::t_word                 back_wdata;
    logic                             back_re;
    logic [dmwbc_pkg::MEM_AW-1:0]     back_raddr;

    // Miss context, held for the whole line transfer.
    logic [dmwbc_pkg::TAG_W-1:0]      r_req_tag;
    logic [dmwbc_pkg::TAG_W-1:0]      r_victim_tag;
    logic [dmwbc_pkg::IDX_W-1:0]      r_req_idx;
    logic [dmwbc_pkg::OFF_W-1:0]      r_req_off;

    // Word step counter for line transfers; top bit set means all words issued.
    logic [dmwbc_pkg::OFF_W:0]        r_cnt;
    logic [dmwbc_pkg::OFF_W-1:0]      prev_word;
    logic                             cnt_done;

    logic [dmwbc_pkg::MEM_AW-1:0]     r_clr;

    // Result registers; a read hit returns the cache read register directly.
    logic                             r_valid_out;
    logic                             r_hit_out;
    logic                             r_sel_mem;
    logic [dmwbc_pkg::PORT_W-1:0]     r_rdata;

    // Request address split.
    logic [dmwbc_pkg::OFF_W-1:0]      in_off;
    logic [dmwbc_pkg::IDX_W-1:0]      in_idx;
    logic [dmwbc_pkg::TAG_W-1:0]      in_tag;
    logic                             req_hit;
    logic                             accept;

    assign in_off  = i_address[dmwbc_pkg::OFF_W-1:0];
    assign in_idx  = i_address[dmwbc_pkg::CACHE_AW-1:dmwbc_pkg::OFF_W];
    assign in_tag  = i_address[dmwbc_pkg::ADDR_W-1:dmwbc_pkg::CACHE_AW];
    assign req_hit = r_valid[in_idx] && (r_tag[in_idx] == in_tag);
    assign accept  = start && !busy;

    assign prev_word = dmwbc_pkg::OFF_W'(r_cnt - 1'b1);
    assign cnt_done  = r_cnt[dmwbc_pkg::OFF_W];

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid_out;
    assign o_hit       = r_hit_out;
    assign o_read_data = r_sel_mem ? dmwbc_pkg::PORT_W'(r_cache_q) : r_rdata;

    // Memory port steering.
    always_comb begin
        cache_we    = 1'b0;
        cache_waddr = '0;
        cache_wdata = '0;
        cache_re    = 1'b0;
        cache_raddr = '0;
        back_we     = 1'b0;
        back_waddr  = '0;
        back_wdata  = '0;
        back_re     = 1'b0;
        back_raddr  = '0;
        unique case (r_state)
            S_CLEAR: begin
                // Sweep the backing store to its reset word.
                back_we    = 1'b1;
                back_waddr = r_clr;
                back_wdata = dmwbc_pkg::RESET_WORD;
            end
            S_IDLE: begin
                if (start) begin
                    if (i_mode) begin
                        // Write through to the backing store always; update the line on a hit.
                        back_we    = 1'b1;
                        back_waddr = dmwbc_pkg::mem_addr(i_address);
                        back_wdata = dmwbc_pkg::WORD_W'(i_write_data);
                        if (req_hit) begin
                            cache_we    = 1'b1;
                            cache_waddr = {in_idx, in_off};
                            cache_wdata = dmwbc_pkg::WORD_W'(i_write_data);
                        end
                    end else begin
                        // Speculative read; used only when the request hits.
                        cache_re    = 1'b1;
                        cache_raddr = {in_idx, in_off};
                    end
                end
            end
            S_WB: begin
                // Read word n from the line while writing word n-1 to the backing store.
                if (!cnt_done) begin
                    cache_re    = 1'b1;
                    cache_raddr = {r_req_idx, r_cnt[dmwbc_pkg::OFF_W-1:0]};
                end
                if (r_cnt != '0) begin
                    back_we    = 1'b1;
                    back_waddr = dmwbc_pkg::mem_addr({r_victim_tag, r_req_idx, prev_word});
                    back_wdata = r_cache_q;
                end
            end
            S_FILL: begin
                // Read word n from the backing store while writing word n-1 into the line.
                if (!cnt_done) begin
                    back_re    = 1'b1;
                    back_raddr = dmwbc_pkg::mem_addr(
                        {r_req_tag, r_req_idx, r_cnt[dmwbc_pkg::OFF_W-1:0]});
                end
                if (r_cnt != '0) begin
                    cache_we    = 1'b1;
                    cache_waddr = {r_req_idx, prev_word};
                    cache_wdata = r_back_q;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cache_we) begin
            r_cache_mem[cache_waddr] <= cache_wdata;
        end
        if (cache_re) begin
            r_cache_q <= r_cache_mem[cache_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (back_we) begin
            r_back_mem[back_waddr] <= back_wdata;
        end
        if (back_re) begin
            r_back_q <= r_back_mem[back_raddr];
        end
    end

    // Sequencer, line metadata and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_valid_out <= 1'b0;
            r_hit_out   <= 1'b0;
            r_sel_mem   <= 1'b0;
            for (int i = 0; i < dmwbc_pkg::LINE_COUNT; i++) begin
                r_tag[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_valid_out <= 1'b0;
                    r_clr       <= r_clr + 1'b1;
                    if (r_clr == dmwbc_pkg::MEM_AW'(dmwbc_pkg::MEM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (i_mode) begin
                            // Write: answer at once with zero data.
                            r_valid_out <= 1'b1;
                            r_hit_out   <= req_hit;
                            r_sel_mem   <= 1'b0;
                            r_rdata     <= '0;
                            if (req_hit) begin
                                r_dirty[in_idx] <= 1'b1;
                            end
                        end else if (req_hit) begin
                            // Read hit: data arrives in the cache read register.
                            r_valid_out <= 1'b1;
                            r_hit_out   <= 1'b1;
                            r_sel_mem   <= 1'b1;
                        end else begin
                            // Read miss: hold the request, evict if dirty, then fill.
                            r_valid_out  <= 1'b0;
                            r_req_tag    <= in_tag;
                            r_req_idx    <= in_idx;
                            r_req_off    <= in_off;
                            r_victim_tag <= r_tag[in_idx];
                            r_cnt        <= '0;
                            r_state      <= r_dirty[in_idx] ? S_WB : S_FILL;
                        end
                    end else begin
                        r_valid_out <= 1'b0;
                    end
                end
                S_WB: begin
                    r_valid_out <= 1'b0;
                    if (cnt_done) begin
                        r_dirty[r_req_idx] <= 1'b0;
                        r_cnt              <= '0;
                        r_state            <= S_FILL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FILL: begin
                    r_cnt       <= r_cnt + 1'b1;
                    r_valid_out <= cnt_done;
                    // Capture the requested word as it passes into the line.
                    if ((r_cnt != '0) && (prev_word == r_req_off)) begin
                        r_rdata <= dmwbc_pkg::PORT_W'(r_back_q);
                    end
                    if (cnt_done) begin
                        r_valid[r_req_idx] <= 1'b1;
                        r_tag[r_req_idx]   <= r_req_tag;
                        r_hit_out          <= 1'b0;
                        r_sel_mem          <= 1'b0;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_valid_out <= 1'b0;
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // Only a valid line can hold modified data.
    a_dirty_implies_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dirty & ~r_valid) == '0)
        else $error("dirty bit set on an invalid line");

    // Writes and read hits answer in the very next cycle.
    a_fast_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode || req_hit)) |=> (o_valid && !busy))
        else $error("single-cycle request did not answer in the next cycle");

    // A read miss holds the block and answers later, never with a hit.
    a_miss_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_mode && !req_hit) |=> (busy && !o_valid))
        else $error("read miss did not start a line transfer");

    // A miss result always reports no hit.
    a_miss_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && cnt_done) |=> (o_valid && !o_hit))
        else $error("fill completion did not deliver a miss result");
`endif

endmodule

`default_nettype wire

/* bench/dmwbc_test_pkg.sv */
// Access kinds and the expected-result record shared by the cache core bench files.
// Depends on dmwbc_pkg for the word type.
`default_nettype none

package dmwbc_test_pkg;

    typedef enum logic {
        ACC_READ  = 1'b0,
        ACC_WRITE = 1'b1
    } t_access;

    typedef struct packed {
        dmwbc_pkg::t_word read_data;
        logic             hit;
    } t_cache_result;

endpackage

`default_nettype wire

/* bench/dmwbc_checker.sv */
// Scoreboard for the cache core: mirrors lines and backing store, predicts each result.
// Depends on dmwbc_pkg and dmwbc_test_pkg; watches the request and result channels only.
`default_nettype none

module dmwbc_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    input  wire logic                                busy,
    input  wire logic                                i_mode,
    input  wire logic [dmwbc_pkg::ADDR_W-1:0]        i_address,
    input  wire logic signed [dmwbc_pkg::PORT_W-1:0] i_write_data,
    input  wire logic                                o_valid,
    input  wire logic signed [dmwbc_pkg::PORT_W-1:0] o_read_data,
    input  wire logic                                o_hit,
    output int                                       pending,
    output int                                       fail_count
);

    localparam int RING_DEPTH = 8;

    logic                          line_ok       [dmwbc_pkg::LINE_COUNT];
    logic                          line_modified [dmwbc_pkg::LINE_COUNT];
    logic [dmwbc_pkg::TAG_W-1:0]   line_tag_q    [dmwbc_pkg::LINE_COUNT];
    dmwbc_pkg::t_word              cached        [dmwbc_pkg::CACHE_WORDS];
    dmwbc_pkg::t_word              backing       [dmwbc_pkg::MEM_WORDS];

    // Expected results in request order; head and tail count pops and pushes.
    dmwbc_test_pkg::t_cache_result awaited_results [RING_DEPTH];
    int                            ring_head;
    int                            ring_tail;

    function automatic void clear_cache_state();
        for (int i = 0; i < dmwbc_pkg::LINE_COUNT; i++) begin
            line_ok[i]       = 1'b0;
            line_modified[i] = 1'b0;
            line_tag_q[i]    = '0;
        end
        for (int i = 0; i < dmwbc_pkg::CACHE_WORDS; i++) cached[i] = '0;
        for (int i = 0; i < dmwbc_pkg::MEM_WORDS; i++) backing[i] = dmwbc_pkg::RESET_WORD;
    endfunction

    // Apply one access to the mirror and return what the core must answer.
    function automatic dmwbc_test_pkg::t_cache_result cache_access(
        dmwbc_test_pkg::t_access mode, logic [dmwbc_pkg::ADDR_W-1:0] addr,
        dmwbc_pkg::t_word data);
        logic [dmwbc_pkg::OFF_W-1:0]   off;
        logic [dmwbc_pkg::IDX_W-1:0]   idx;
        logic [dmwbc_pkg::TAG_W-1:0]   tg;
        int                            base;
        int                            victim_base;
        int                            fill_base;
        dmwbc_test_pkg::t_cache_result r;
        off  = addr[dmwbc_pkg::OFF_W-1:0];
        idx  = addr[dmwbc_pkg::OFF_W +: dmwbc_pkg::IDX_W];
        tg   = addr[dmwbc_pkg::ADDR_W-1 -: dmwbc_pkg::TAG_W];
        base = int'(idx) * dmwbc_pkg::WORDS_PER_LINE;
        r.hit       = line_ok[idx] && (line_tag_q[idx] == tg);
        r.read_data = '0;
        if (mode == dmwbc_test_pkg::ACC_READ) begin
            if (!r.hit) begin
                if (line_modified[idx]) begin
                    victim_base = (int'(line_tag_q[idx]) * dmwbc_pkg::LINE_COUNT + int'(idx))
                                  * dmwbc_pkg::WORDS_PER_LINE;
                    for (int i = 0; i < dmwbc_pkg::WORDS_PER_LINE; i++)
                        backing[(victim_base + i) % dmwbc_pkg::MEM_WORDS] = cached[base + i];
                    line_modified[idx] = 1'b0;
                end
                fill_base = int'(addr) - int'(off);
                for (int i = 0; i < dmwbc_pkg::WORDS_PER_LINE; i++)
                    cached[base + i] = backing[(fill_base + i) % dmwbc_pkg::MEM_WORDS];
                line_tag_q[idx] = tg;
                line_ok[idx]    = 1'b1;
            end
            r.read_data = cached[base + int'(off)];
        end else begin
            if (r.hit) begin
                cached[base + int'(off)] = data;
                line_modified[idx]       = 1'b1;
            end
            backing[int'(addr) % dmwbc_pkg::MEM_WORDS] = data;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        dmwbc_test_pkg::t_cache_result want;
        if (!i_rst_n) begin
            clear_cache_state();
            ring_head  = 0;
            ring_tail  = 0;
            pending    = 0;
            fail_count = 0;
        end else begin
            if (o_valid === 1'b1) begin
                if (ring_tail == ring_head) begin
                    $error("unexpected result: read_data %h hit %b", o_read_data, o_hit);
                    fail_count++;
                end else begin
                    want = awaited_results[ring_head % RING_DEPTH];
                    ring_head++;
                    if ($unsigned(o_read_data) !== want.read_data) begin
                        $error("read_data mismatch: expected %h, actual %h",
                               want.read_data, o_read_data);
                        fail_count++;
                    end
                    if (o_hit !== want.hit) begin
                        $error("hit mismatch: expected %b, actual %b", want.hit, o_hit);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                awaited_results[ring_tail % RING_DEPTH] =
                    cache_access(dmwbc_test_pkg::t_access'(i_mode), i_address,
                                 $unsigned(i_write_data));
                ring_tail++;
            end
            pending = ring_tail - ring_head;
        end
    end

endmodule

`default_nettype wire

/* bench/direct_mapped_writeback_cache_core_test.sv */
// Top of the cache core bench: clock, reset, request stimulus, watchdog and verdict.
// Depends on the core, dmwbc_pkg, dmwbc_test_pkg and the dmwbc_checker scoreboard.
`default_nettype none

module direct_mapped_writeback_cache_core_test;

    localparam int RANDOM_REQUESTS = 1330;
    localparam int QUIET_TAIL      = 150;   // last requests go back to back
    localparam int DRAIN_EVERY     = 400;
    localparam int IDLE_MAX        = 11;
    localparam int SETTLE_CYCLES   = 40;    // longer than a dirty read miss
    // Longest quiet stretch of a correct run: the sweep after reset, or the longest
    // idle pause followed by a dirty read miss. Take it many times over.
    localparam int WATCHDOG_LIMIT  = 4000;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic                                i_mode;
    logic [dmwbc_pkg::ADDR_W-1:0]        i_address;
    logic signed [dmwbc_pkg::PORT_W-1:0] i_write_data;
    logic                                o_valid;
    logic signed [dmwbc_pkg::PORT_W-1:0] o_read_data;
    logic                                o_hit;

    int pending;
    int fail_count;
    int quiet_cycles = 0;

    // Per-index favorite tag: keeps most random traffic on a few lines so
    // hits, dirty lines and write-backs happen often.
    logic [dmwbc_pkg::TAG_W-1:0] hot_tag [dmwbc_pkg::LINE_COUNT];

    direct_mapped_writeback_cache_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .o_read_data  (o_read_data),
        .o_hit        (o_hit)
    );

    dmwbc_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .o_read_data  (o_read_data),
        .o_hit        (o_hit),
        .pending      (pending),
        .fail_count   (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Count cycles with neither a request taken nor a result strobed.
    always @(posedge i_clk) begin
        if ((start && !busy) || (o_valid === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("direct_mapped_writeback_cache_core_test NOT OK");
            $finish;
        end
    end

    // Present one request at the falling edge and hold it until the core takes it.
    task automatic issue(dmwbc_test_pkg::t_access mode, logic [dmwbc_pkg::ADDR_W-1:0] addr,
                         logic [dmwbc_pkg::PORT_W-1:0] data);
        @(negedge i_clk);
        start        <= 1'b1;
        i_mode       <= mode;
        i_address    <= addr;
        i_write_data <= data;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start for a pause, scrambling the request fields meanwhile; they must be ignored.
    task automatic pause(int n);
        for (int i = 0; i < n; i++) begin
            @(negedge i_clk);
            start        <= 1'b0;
            i_mode       <= 1'($urandom);
            i_address    <= dmwbc_pkg::ADDR_W'($urandom);
            i_write_data <= $urandom;
        end
    endtask

    // Hold off until every outstanding request has answered.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [dmwbc_pkg::PORT_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic dmwbc_test_pkg::t_access pick_mode();
        return ($urandom_range(0, 9) < 6) ? dmwbc_test_pkg::ACC_READ : dmwbc_test_pkg::ACC_WRITE;
    endfunction

    function automatic logic [dmwbc_pkg::ADDR_W-1:0] pick_address();
        logic [dmwbc_pkg::IDX_W-1:0] idx;
        logic [dmwbc_pkg::TAG_W-1:0] tg;
        idx = dmwbc_pkg::IDX_W'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            // Stray tag: usually misses and, on reads, evicts; sometimes move the focus.
            tg = dmwbc_pkg::TAG_W'($urandom);
            if ($urandom_range(0, 1) == 1) hot_tag[idx] = tg;
        end else begin
            tg = hot_tag[idx];
        end
        return {tg, idx, dmwbc_pkg::OFF_W'($urandom)};
    endfunction

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_mode       = 1'b0;
        i_address    = '0;
        i_write_data = '0;
        for (int i = 0; i < dmwbc_pkg::LINE_COUNT; i++) hot_tag[i] = dmwbc_pkg::TAG_W'($urandom);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part; the first request waits out the post-reset sweep.
        issue(dmwbc_test_pkg::ACC_READ,  8'h00, pick_word());   // clean read miss, reset word
        issue(dmwbc_test_pkg::ACC_READ,  8'h0f, pick_word());   // read hit, last word of line
        issue(dmwbc_test_pkg::ACC_WRITE, 8'h05, 32'h7fff_ffff); // write hit, line goes dirty
        issue(dmwbc_test_pkg::ACC_WRITE, 8'h80, 32'h8000_0000); // write miss: memory only
        issue(dmwbc_test_pkg::ACC_READ,  8'h80, pick_word());   // dirty victim write-back, fill
        issue(dmwbc_test_pkg::ACC_READ,  8'h05, pick_word());   // refill sees written-back word
        issue(dmwbc_test_pkg::ACC_READ,  8'h85, pick_word());   // clean eviction
        issue(dmwbc_test_pkg::ACC_READ,  8'hff, pick_word());   // highest address
        issue(dmwbc_test_pkg::ACC_WRITE, 8'hff, 32'hffff_ffff);
        issue(dmwbc_test_pkg::ACC_READ,  8'hff, pick_word());
        issue(dmwbc_test_pkg::ACC_WRITE, 8'hff, 32'h0000_0000);
        issue(dmwbc_test_pkg::ACC_READ,  8'hf0, pick_word());
        issue(dmwbc_test_pkg::ACC_WRITE, 8'h00, 32'hdead_beef); // write miss, index holds tag 2
        drain();                                                // let the queue run dry once
        issue(dmwbc_test_pkg::ACC_READ,  8'h00, pick_word());
        issue(dmwbc_test_pkg::ACC_WRITE, 8'h3a, 32'h1234_5678); // write miss, line holds tag 3
        issue(dmwbc_test_pkg::ACC_READ,  8'h3a, pick_word());
        issue(dmwbc_test_pkg::ACC_WRITE, 8'h3b, 32'h8765_4321);
        issue(dmwbc_test_pkg::ACC_WRITE, 8'h7b, 32'h0000_0001); // miss, same index, other tag
        issue(dmwbc_test_pkg::ACC_READ,  8'h7b, pick_word());   // dirty write-back of 0x30 block
        issue(dmwbc_test_pkg::ACC_READ,  8'h3b, pick_word());
        pause(3);
        issue(dmwbc_test_pkg::ACC_READ,  8'hc0, pick_word());

        // Random traffic, mostly on favored tags, with idle bursts until the tail.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            issue(pick_mode(), pick_address(), pick_word());
            if (n < RANDOM_REQUESTS - QUIET_TAIL) begin
                if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                    drain();
                else if ($urandom_range(0, 3) == 0)
                    pause($urandom_range(1, IDLE_MAX));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("direct_mapped_writeback_cache_core_test OK");
        else
            $display("direct_mapped_writeback_cache_core_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
